FILE: hdl/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, register indexes and coefficient tables for the YUYV to
// RGB888 converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SWAP_ROWS    = 2'd2
  } reg_idx_t;

  localparam int CfgDataW = 13;

  // coefficients in decimal fixed point, scale 10^6
  localparam int ScaleDen     = 1000000;
  localparam int RvFix        = 1370705;
  localparam int GvFix        = 698001;
  localparam int GuFix        = 337633;
  localparam int BuFix        = 1732446;
  localparam int ChromaOffset = 128;

  typedef logic signed [8:0] coef_t;
  typedef coef_t coef_tbl_t [0:255];

  // position fields, sized for the largest geometry
  typedef logic [12:0] row_idx_t;
  typedef logic [11:0] col_idx_t;

  typedef struct packed {
    row_idx_t row_idx;  // row as placed in the output frame
    col_idx_t col;
    logic     last;
  } pos_t;

  // table entry i = trunc((i - 128) * coef / 10^6), toward zero
  function automatic coef_tbl_t build_coef_tbl(input int coef);
    coef_tbl_t tbl;
    int        prod;
    for (int i = 0; i < 256; i++) begin
      prod   = (i - ChromaOffset) * coef;
      tbl[i] = coef_t'(prod / ScaleDen);
    end
    return tbl;
  endfunction

  // clamp a signed sum to 0..255
  function automatic logic [7:0] clamp8(input logic signed [10:0] s);
    logic [7:0] res;
    if (s < 0) begin
      res = 8'd0;
    end else if (s > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = s[7:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/yuyv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_converter_unit
// Packed YUYV 4:2:2 to RGB888 converter with frame position tracking.
// ----------------------------------------------------------------------------
// Takes one YUYV word per clock and gives two clamped RGB888 pixels, the
// pair's position in the frame and a last-of-frame flag. The first stage
// registers the chroma coefficient ROM reads and the frame counters, the
// second does the sums, clamps and the row times pairs-per-row multiply
// into the output register. Throughput is one word per cycle as long as
// out_stall is low; out_stall backs up through the two stages into
// in_stall. With swap_rows set, rows are numbered bottom-up. Write the
// geometry registers only while no word is in flight.
module yuyv_to_rgb_converter_unit #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_luma_first,
  input  logic [7:0]                   in_chroma_blue,
  input  logic [7:0]                   in_luma_second,
  input  logic [7:0]                   in_chroma_red,
  // result words
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_red_first,
  output logic [7:0]                   out_green_first,
  output logic [7:0]                   out_blue_first,
  output logic [7:0]                   out_red_second,
  output logic [7:0]                   out_green_second,
  output logic [7:0]                   out_blue_second,
  output logic [22:0]                  out_pair_index,
  output logic                         out_last_of_frame,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  y2r_pkg::reg_idx_t            cfg_index,
  input  logic [y2r_pkg::CfgDataW-1:0] cfg_data
);

  localparam int PairW = $clog2(MAX_WIDTH / 2 + 1);
  localparam int RowsW = $clog2(MAX_HEIGHT + 1);
  localparam int PosW  = $bits(y2r_pkg::row_idx_t) + PairW + 1;

  // configuration registers
  logic [12:0] frame_width_r;
  logic [12:0] frame_height_r;
  logic        swap_rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 13'd320;
      frame_height_r <= 13'd240;
      swap_rows_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        y2r_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        y2r_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        y2r_pkg::REG_SWAP_ROWS:    swap_rows_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [13:0]      width_clip;
  logic [13:0]      height_clip;
  logic [PairW-1:0] pairs;
  logic [RowsW-1:0] rows;

  always_comb begin
    width_clip = {1'b0, frame_width_r};
    if (width_clip < 14'd2) begin
      width_clip = 14'd2;
    end else if (width_clip > 14'(MAX_WIDTH)) begin
      width_clip = 14'(MAX_WIDTH);
    end
    height_clip = {1'b0, frame_height_r};
    if (height_clip < 14'd1) begin
      height_clip = 14'd1;
    end else if (height_clip > 14'(MAX_HEIGHT)) begin
      height_clip = 14'(MAX_HEIGHT);
    end
  end

  assign pairs = PairW'(width_clip >> 1);
  assign rows  = RowsW'(height_clip);

  // pipeline flow control
  logic s1_valid_r;
  logic out_valid_r;
  logic out_en;
  logic s1_en;
  logic in_fire;

  assign out_en   = !out_valid_r || !out_stall;
  assign s1_en    = !s1_valid_r || out_en;
  assign in_stall = !s1_en;
  assign in_fire  = in_valid && s1_en;

  // stage 1: coefficient lookup and frame position
  y2r_pkg::coef_t red_v;
  y2r_pkg::coef_t green_u;
  y2r_pkg::coef_t green_v;
  y2r_pkg::coef_t blue_u;
  y2r_pkg::pos_t  pos_cur;
  y2r_pkg::pos_t  s1_pos_r;
  logic [7:0]     s1_luma0_r;
  logic [7:0]     s1_luma1_r;

  y2r_coef_rom u_coef_rom (
    .clk      (clk),
    .rd_en    (in_fire),
    .chroma_u (in_chroma_blue),
    .chroma_v (in_chroma_red),
    .red_v    (red_v),
    .green_u  (green_u),
    .green_v  (green_v),
    .blue_u   (blue_u)
  );

  y2r_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos_ctr (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .swap_rows (swap_rows_r),
    .pairs     (pairs),
    .rows      (rows),
    .pos       (pos_cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_luma0_r <= in_luma_first;
      s1_luma1_r <= in_luma_second;
      s1_pos_r   <= pos_cur;
    end
  end

  // stage 2: sums, clamp, linear position
  logic signed [10:0] luma0_s;
  logic signed [10:0] luma1_s;
  logic signed [10:0] rd_s;
  logic signed [10:0] gd_s;
  logic signed [10:0] bd_s;
  logic [PosW-1:0]    pos_full;

  assign luma0_s = $signed({3'b000, s1_luma0_r});
  assign luma1_s = $signed({3'b000, s1_luma1_r});
  assign rd_s    = $signed({{2{red_v[8]}}, red_v});
  assign bd_s    = $signed({{2{blue_u[8]}}, blue_u});
  assign gd_s    = $signed({{2{green_u[8]}}, green_u}) + $signed({{2{green_v[8]}}, green_v});

  assign pos_full = PosW'(s1_pos_r.row_idx) * PosW'(pairs) + PosW'(s1_pos_r.col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_red_first     <= y2r_pkg::clamp8(luma0_s + rd_s);
      out_green_first   <= y2r_pkg::clamp8(luma0_s - gd_s);
      out_blue_first    <= y2r_pkg::clamp8(luma0_s + bd_s);
      out_red_second    <= y2r_pkg::clamp8(luma1_s + rd_s);
      out_green_second  <= y2r_pkg::clamp8(luma1_s - gd_s);
      out_blue_second   <= y2r_pkg::clamp8(luma1_s + bd_s);
      out_pair_index    <= 23'(pos_full);
      out_last_of_frame <= s1_pos_r.last;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // input backs up only when both stages are full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

  // a word in stage 1 moves on when the output register is free
  a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_valid_r |=> out_valid_r)
    else $error("stage 1 word did not reach the output register");
`endif

endmodule

FILE: hdl/y2r_coef_rom.sv
// ----------------------------------------------------------------------------
// y2r_coef_rom
// Chroma coefficient ROMs with a registered read port, one lookup per word.
// ----------------------------------------------------------------------------
module y2r_coef_rom (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [7:0]            chroma_u,
  input  logic [7:0]            chroma_v,
  output y2r_pkg::coef_t        red_v,
  output y2r_pkg::coef_t        green_u,
  output y2r_pkg::coef_t        green_v,
  output y2r_pkg::coef_t        blue_u
);

  localparam y2r_pkg::coef_tbl_t RvRom = y2r_pkg::build_coef_tbl(y2r_pkg::RvFix);
  localparam y2r_pkg::coef_tbl_t GvRom = y2r_pkg::build_coef_tbl(y2r_pkg::GvFix);
  localparam y2r_pkg::coef_tbl_t GuRom = y2r_pkg::build_coef_tbl(y2r_pkg::GuFix);
  localparam y2r_pkg::coef_tbl_t BuRom = y2r_pkg::build_coef_tbl(y2r_pkg::BuFix);

  y2r_pkg::coef_t red_v_r;
  y2r_pkg::coef_t green_u_r;
  y2r_pkg::coef_t green_v_r;
  y2r_pkg::coef_t blue_u_r;

  // synchronous read, data held while the pipeline is stalled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      red_v_r   <= RvRom[chroma_v];
      green_v_r <= GvRom[chroma_v];
      green_u_r <= GuRom[chroma_u];
      blue_u_r  <= BuRom[chroma_u];
    end
  end

  assign red_v   = red_v_r;
  assign green_u = green_u_r;
  assign green_v = green_v_r;
  assign blue_u  = blue_u_r;

endmodule

FILE: hdl/y2r_pos_ctr.sv
// ----------------------------------------------------------------------------
// y2r_pos_ctr
// Column and row counters for the pair stream; gives the placed row, the
// column and the last-of-frame flag for each word.
// ----------------------------------------------------------------------------
module y2r_pos_ctr #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  logic                                   swap_rows,
  input  logic [$clog2(MAX_WIDTH / 2 + 1) - 1:0] pairs,
  input  logic [$clog2(MAX_HEIGHT + 1) - 1:0]    rows,
  output y2r_pkg::pos_t                          pos
);

  localparam int PairW = $clog2(MAX_WIDTH / 2 + 1);
  localparam int RowsW = $clog2(MAX_HEIGHT + 1);
  localparam int ColW  = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
  localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  logic [ColW-1:0]  col_r, col_nxt;
  logic [RowW-1:0]  row_r, row_nxt;
  logic             restart;
  logic [ColW-1:0]  col_cur;
  logic [RowW-1:0]  row_cur;
  logic [ColW:0]    col_inc;
  logic [RowW:0]    row_inc;
  logic [RowsW-1:0] rows_m1;
  logic [PairW-1:0] pairs_m1;
  logic [RowsW-1:0] row_flip;

  // counters left outside the geometry restart the frame
  assign restart = (col_r >= pairs) || (row_r >= rows);
  assign col_cur = restart ? '0 : col_r;
  assign row_cur = restart ? '0 : row_r;

  assign rows_m1  = rows - RowsW'(1);
  assign pairs_m1 = pairs - PairW'(1);
  assign row_flip = rows_m1 - RowsW'(row_cur);

  // position of the current word
  always_comb begin
    pos.row_idx = swap_rows ? y2r_pkg::row_idx_t'(row_flip)
                            : y2r_pkg::row_idx_t'(row_cur);
    pos.col     = y2r_pkg::col_idx_t'(col_cur);
    pos.last    = (PairW'(col_cur) == pairs_m1) && (RowsW'(row_cur) == rows_m1);
  end

  // advance column, wrap into the next row, wrap the frame
  assign col_inc = {1'b0, col_cur} + (ColW + 1)'(1);
  assign row_inc = {1'b0, row_cur} + (RowW + 1)'(1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (col_inc >= pairs) begin
        col_nxt = '0;
        row_nxt = (row_inc >= rows) ? '0 : row_inc[RowW-1:0];
      end else begin
        col_nxt = col_inc[ColW-1:0];
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

`ifndef SYNTHESIS
  // frame end brings both counters back to zero
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step && pos.last |=> col_r == '0 && row_r == '0)
    else $error("counters did not wrap after last word of frame");

  // after a step the column lies inside the row
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> col_r < $past(pairs))
    else $error("column counter beyond row length");
`endif

endmodule
